[rtl/core/rbe_pkg.sv]
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types, constants and the microcode program of the rigid-body
// midpoint integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbe_pkg;

    // number format and run length
    localparam int FRAC_BITS = 24;
    localparam int MAX_STEPS = 1024;
    localparam int CNT_W     = $clog2(MAX_STEPS);
    localparam int LIM_W     = CNT_W + 1;
    localparam int DATA_W    = 32;
    localparam int STEP_W    = 31;
    localparam int TOT_W     = 11;
    localparam int IDX_W     = 10;

    // register file of the configuration port
    localparam int NUM_REGS  = 8;
    localparam int ADDR_W    = $clog2(NUM_REGS * 4);

    // reset values of the configuration registers
    localparam logic [STEP_W-1:0]        RST_STEP  = 31'd167772;
    localparam logic signed [DATA_W-1:0] RST_GX    = 32'sd10066330;
    localparam logic signed [DATA_W-1:0] RST_GY    = -32'sd13421773;
    localparam logic signed [DATA_W-1:0] RST_GZ    = 32'sd6452775;
    localparam logic signed [DATA_W-1:0] RST_INIT  = 32'sd16777216;
    localparam logic [TOT_W-1:0]         RST_TOTAL = 11'd800;

    typedef enum logic [2:0] {
        REG_STEP  = 3'd0,
        REG_GX    = 3'd1,
        REG_GY    = 3'd2,
        REG_GZ    = 3'd3,
        REG_INITX = 3'd4,
        REG_INITY = 3'd5,
        REG_INITZ = 3'd6,
        REG_TOTAL = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [STEP_W-1:0]        step_size;
        logic signed [DATA_W-1:0] gamma_x;
        logic signed [DATA_W-1:0] gamma_y;
        logic signed [DATA_W-1:0] gamma_z;
        logic signed [DATA_W-1:0] init_x;
        logic signed [DATA_W-1:0] init_y;
        logic signed [DATA_W-1:0] init_z;
        logic [TOT_W-1:0]         total_steps;
    } t_cfg;

    // microcode program counter
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
    localparam logic [PC_W-1:0] PC_EMIT = 5'd2;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_REQ   = 3'd2,
        COND_OVER     = 3'd3,
        COND_OUT_BUSY = 3'd4
    } t_cond;

    // multiplier operand a: step size, h*gamma products, chain temporaries
    typedef enum logic [2:0] {
        A_STEP = 3'd0,
        A_HX   = 3'd1,
        A_HY   = 3'd2,
        A_HZ   = 3'd3,
        A_TX   = 3'd4,
        A_TY   = 3'd5,
        A_TZ   = 3'd6
    } t_asel;

    // multiplier operand b: gammas, state vector, midpoint vector
    typedef enum logic [3:0] {
        B_GX = 4'd0,
        B_GY = 4'd1,
        B_GZ = 4'd2,
        B_VX = 4'd3,
        B_VY = 4'd4,
        B_VZ = 4'd5,
        B_MX = 4'd6,
        B_MY = 4'd7,
        B_MZ = 4'd8
    } t_bsel;

    // product destination
    typedef enum logic [2:0] {
        D_HX = 3'd0,
        D_HY = 3'd1,
        D_HZ = 3'd2,
        D_TX = 3'd3,
        D_TY = 3'd4,
        D_TZ = 3'd5
    } t_dsel;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    // one control word
    typedef struct packed {
        t_cond            cond;
        logic [PC_W-1:0]  target;
        logic             take;
        logic             emit;
        logic             mul_en;
        t_asel            mul_a;
        t_bsel            mul_b;
        t_dsel            mul_dst;
        logic             add_en;
        t_axis            add_axis;
        logic             add_final;
    } t_uop;

    // status seen by the jump logic
    typedef struct packed {
        logic req;
        logic over;
        logic out_busy;
    } t_flags;

    function automatic t_uop set_mul(input t_uop w, input t_asel a, input t_bsel b,
                                     input t_dsel d);
        t_uop r;
        r         = w;
        r.mul_en  = 1'b1;
        r.mul_a   = a;
        r.mul_b   = b;
        r.mul_dst = d;
        return r;
    endfunction

    function automatic t_uop set_add(input t_uop w, input t_axis ax, input logic fin);
        t_uop r;
        r           = w;
        r.add_en    = 1'b1;
        r.add_axis  = ax;
        r.add_final = fin;
        return r;
    endfunction

    // program: wait for a request, check the run, emit, then one rk2 step.
    // a product is written back one step after issue and is usable a step later
    function automatic t_uop rom_word(input logic [PC_W-1:0] pc);
        t_uop w;
        w = '0;
        unique case (pc)
            5'd0: begin
                w.take   = 1'b1;
                w.cond   = COND_NO_REQ;
                w.target = PC_IDLE;
            end
            5'd1: begin
                w.cond   = COND_OVER;
                w.target = PC_IDLE;
            end
            5'd2: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = PC_EMIT;
            end
            5'd3:  w = set_mul(w, A_STEP, B_GX, D_HX);
            5'd4:  w = set_mul(w, A_STEP, B_GY, D_HY);
            5'd5:  w = set_mul(w, A_STEP, B_GZ, D_HZ);
            5'd6:  w = set_mul(w, A_HX, B_VY, D_TX);
            5'd7:  w = set_mul(w, A_HY, B_VX, D_TY);
            5'd8:  w = set_mul(w, A_HZ, B_VX, D_TZ);
            5'd9:  w = set_mul(w, A_TX, B_VZ, D_TX);
            5'd10: w = set_mul(w, A_TY, B_VZ, D_TY);
            5'd11: w = set_add(set_mul(w, A_TZ, B_VY, D_TZ), AX_X, 1'b0);
            5'd12: w = set_add(set_mul(w, A_HY, B_MX, D_TY), AX_Y, 1'b0);
            5'd13: w = set_add(set_mul(w, A_HX, B_MY, D_TX), AX_Z, 1'b0);
            5'd14: w = set_mul(w, A_HZ, B_MX, D_TZ);
            5'd15: w = set_mul(w, A_TY, B_MZ, D_TY);
            5'd16: w = set_mul(w, A_TX, B_MZ, D_TX);
            5'd17: w = set_add(set_mul(w, A_TZ, B_MY, D_TZ), AX_Y, 1'b1);
            5'd18: w = set_add(w, AX_X, 1'b1);
            5'd19: begin
                w        = set_add(w, AX_Z, 1'b1);
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rigid_body_euler_rk2_step.sv]
// ----------------------------------------------------------------------------
// rigid_body_euler_rk2_step
// Torque-free rigid-body angular velocity integrator, midpoint rk2 step,
// signed Q8.24 state, microcoded around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid / o_stall, payload i_restart): one request per
//   tick. restart=1 reloads the vector from init_x/y/z and starts at sample 0.
//   Output channel (o_valid / i_stall): one sample per producing tick, the
//   vector before the step, its index in the run and a last flag.
//   A tick after the final sample of a run gives no output and holds state.
//   The sample is registered at the emit step, after take and run check.
//   A producing request occupies the sequencer through three control steps,
//   15 products through the single 33x32 multiplier, each written back in
//   the cycle after issue, and two closing update sums (the midpoint and
//   first update sums overlap the products); a tick on a finished run
//   passes only the take and run-check steps.
//   A stalled sample waits in the output register while the next step is
//   computed; the next sample waits for that register to free up.
//   Configuration: APB-style, 32-bit registers at 4*index, to be written
//   only while idle (the block does not enforce it). Reset loads the register
//   defaults, the default vector and sample index 0, with no output pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rigid_body_euler_rk2_step (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rbe_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // request channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_restart,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [31:0]              o_omega_x,
    output logic signed [31:0]              o_omega_y,
    output logic signed [31:0]              o_omega_z,
    output logic [rbe_pkg::IDX_W-1:0]       o_step_index,
    output logic                            o_last
);

    localparam int CW = rbe_pkg::CNT_W;
    localparam int LW = rbe_pkg::LIM_W;

    rbe_pkg::t_cfg   w_cfg;
    rbe_pkg::t_uop   w_uop;
    rbe_pkg::t_flags w_flags;

    logic signed [rbe_pkg::DATA_W-1:0] w_vx, w_vy, w_vz;

    logic [CW-1:0] r_cnt;
    logic [LW-1:0] w_limit;
    logic          w_over;
    logic          w_is_last;
    logic          w_accept;
    logic          w_load;
    logic          w_out_busy;
    logic          w_emit;
    logic          r_out_valid;

    rbe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rbe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uop   (w_uop)
    );

    rbe_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uop   (w_uop),
        .i_cfg   (w_cfg),
        .i_load  (w_load),
        .o_vel_x (w_vx),
        .o_vel_y (w_vy),
        .o_vel_z (w_vz)
    );

    // request handshake
    assign o_stall  = !w_uop.take;
    assign w_accept = i_valid && !o_stall;
    assign w_load   = w_accept && i_restart;

    // run length clamped to [2, MAX_STEPS]
    always_comb begin
        if (w_cfg.total_steps < 2) begin
            w_limit = LW'(2);
        end else if (int'(w_cfg.total_steps) > rbe_pkg::MAX_STEPS) begin
            w_limit = LW'(rbe_pkg::MAX_STEPS);
        end else begin
            w_limit = LW'(w_cfg.total_steps);
        end
    end

    assign w_over    = {1'b0, r_cnt} >= (w_limit - 1'b1);
    assign w_is_last = {1'b0, r_cnt} == (w_limit - LW'(2));

    // sequencer status
    assign w_out_busy     = r_out_valid && i_stall;
    assign w_emit         = w_uop.emit && !w_out_busy;
    assign w_flags.req      = i_valid;
    assign w_flags.over     = w_over;
    assign w_flags.out_busy = w_out_busy;

    // sample counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_load) begin
            r_cnt <= '0;
        end else if (w_emit) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_omega_x    <= w_vx;
            o_omega_y    <= w_vy;
            o_omega_z    <= w_vz;
            o_step_index <= rbe_pkg::IDX_W'(r_cnt);
            o_last       <= w_is_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/core/rbe_regs.sv]
// ----------------------------------------------------------------------------
// rbe_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbe_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rbe_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output rbe_pkg::t_cfg                   o_cfg
);

    rbe_pkg::t_cfg      r_cfg;
    rbe_pkg::t_reg_idx  w_idx;
    logic               w_wr;

    assign w_idx  = rbe_pkg::t_reg_idx'(paddr[rbe_pkg::ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size   <= rbe_pkg::RST_STEP;
            r_cfg.gamma_x     <= rbe_pkg::RST_GX;
            r_cfg.gamma_y     <= rbe_pkg::RST_GY;
            r_cfg.gamma_z     <= rbe_pkg::RST_GZ;
            r_cfg.init_x      <= rbe_pkg::RST_INIT;
            r_cfg.init_y      <= rbe_pkg::RST_INIT;
            r_cfg.init_z      <= rbe_pkg::RST_INIT;
            r_cfg.total_steps <= rbe_pkg::RST_TOTAL;
        end else if (w_wr) begin
            unique case (w_idx)
                rbe_pkg::REG_STEP:  r_cfg.step_size   <= pwdata[rbe_pkg::STEP_W-1:0];
                rbe_pkg::REG_GX:    r_cfg.gamma_x     <= pwdata;
                rbe_pkg::REG_GY:    r_cfg.gamma_y     <= pwdata;
                rbe_pkg::REG_GZ:    r_cfg.gamma_z     <= pwdata;
                rbe_pkg::REG_INITX: r_cfg.init_x      <= pwdata;
                rbe_pkg::REG_INITY: r_cfg.init_y      <= pwdata;
                rbe_pkg::REG_INITZ: r_cfg.init_z      <= pwdata;
                rbe_pkg::REG_TOTAL: r_cfg.total_steps <= pwdata[rbe_pkg::TOT_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            rbe_pkg::REG_STEP:  prdata = 32'(r_cfg.step_size);
            rbe_pkg::REG_GX:    prdata = r_cfg.gamma_x;
            rbe_pkg::REG_GY:    prdata = r_cfg.gamma_y;
            rbe_pkg::REG_GZ:    prdata = r_cfg.gamma_z;
            rbe_pkg::REG_INITX: prdata = r_cfg.init_x;
            rbe_pkg::REG_INITY: prdata = r_cfg.init_y;
            rbe_pkg::REG_INITZ: prdata = r_cfg.init_z;
            rbe_pkg::REG_TOTAL: prdata = 32'(r_cfg.total_steps);
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/rbe_seq.sv]
// ----------------------------------------------------------------------------
// rbe_seq
// Microcode sequencer: program counter, control store and jump logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbe_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rbe_pkg::t_flags i_flags,
    output rbe_pkg::t_uop        o_uop
);

    logic [rbe_pkg::PC_W-1:0] r_pc;
    logic [rbe_pkg::PC_W-1:0] n_pc;
    rbe_pkg::t_uop            w_uop;
    logic                     w_jump;

    assign w_uop = rbe_pkg::rom_word(r_pc);
    assign o_uop = w_uop;

    // jump condition
    always_comb begin
        unique case (w_uop.cond)
            rbe_pkg::COND_NEVER:    w_jump = 1'b0;
            rbe_pkg::COND_ALWAYS:   w_jump = 1'b1;
            rbe_pkg::COND_NO_REQ:   w_jump = !i_flags.req;
            rbe_pkg::COND_OVER:     w_jump = i_flags.over;
            rbe_pkg::COND_OUT_BUSY: w_jump = i_flags.out_busy;
            default:                w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uop.target : r_pc + 1'b1;
    end

    // program counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rbe_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rbe_dp.sv]
// ----------------------------------------------------------------------------
// rbe_dp
// Datapath: state and scratch registers, one shared rounding multiplier
// and one saturating accumulate unit, steered by the control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbe_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rbe_pkg::t_uop             i_uop,
    input  wire rbe_pkg::t_cfg             i_cfg,
    input  wire logic                      i_load,
    output logic signed [rbe_pkg::DATA_W-1:0] o_vel_x,
    output logic signed [rbe_pkg::DATA_W-1:0] o_vel_y,
    output logic signed [rbe_pkg::DATA_W-1:0] o_vel_z
);

    localparam int DW = rbe_pkg::DATA_W;
    localparam int PW = 2 * DW + 1;
    localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (rbe_pkg::FRAC_BITS - 1);
    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    // state vector, h*gamma, chain temporaries, midpoint
    logic signed [DW-1:0] r_vx, r_vy, r_vz;
    logic signed [DW-1:0] r_hx, r_hy, r_hz;
    logic signed [DW-1:0] r_tx, r_ty, r_tz;
    logic signed [DW-1:0] r_mx, r_my, r_mz;

    // multiplier pipeline
    logic signed [DW:0]   w_op_a;
    logic signed [DW-1:0] w_op_b;
    logic signed [PW-1:0] r_prod;
    logic                 r_wb_en;
    rbe_pkg::t_dsel       r_wb_dst;
    logic signed [PW-1:0] w_rnd;
    logic signed [PW-1:0] w_shr;
    logic signed [DW-1:0] w_wb;

    // accumulate unit
    logic signed [DW-1:0] w_v;
    logic signed [DW-1:0] w_t;
    logic signed [DW-1:0] w_neg;
    logic signed [DW-1:0] w_inc;
    logic signed [DW:0]   w_sum;
    logic signed [DW-1:0] w_acc;

    assign o_vel_x = r_vx;
    assign o_vel_y = r_vy;
    assign o_vel_z = r_vz;

    // operand a: step size is unsigned, the rest signed
    always_comb begin
        case (i_uop.mul_a)
            rbe_pkg::A_STEP: w_op_a = {2'b00, i_cfg.step_size};
            rbe_pkg::A_HX:   w_op_a = {r_hx[DW-1], r_hx};
            rbe_pkg::A_HY:   w_op_a = {r_hy[DW-1], r_hy};
            rbe_pkg::A_HZ:   w_op_a = {r_hz[DW-1], r_hz};
            rbe_pkg::A_TX:   w_op_a = {r_tx[DW-1], r_tx};
            rbe_pkg::A_TY:   w_op_a = {r_ty[DW-1], r_ty};
            rbe_pkg::A_TZ:   w_op_a = {r_tz[DW-1], r_tz};
            default:         w_op_a = '0;
        endcase
    end

    // operand b
    always_comb begin
        case (i_uop.mul_b)
            rbe_pkg::B_GX: w_op_b = i_cfg.gamma_x;
            rbe_pkg::B_GY: w_op_b = i_cfg.gamma_y;
            rbe_pkg::B_GZ: w_op_b = i_cfg.gamma_z;
            rbe_pkg::B_VX: w_op_b = r_vx;
            rbe_pkg::B_VY: w_op_b = r_vy;
            rbe_pkg::B_VZ: w_op_b = r_vz;
            rbe_pkg::B_MX: w_op_b = r_mx;
            rbe_pkg::B_MY: w_op_b = r_my;
            rbe_pkg::B_MZ: w_op_b = r_mz;
            default:       w_op_b = '0;
        endcase
    end

    // product register and write-back tag
    always_ff @(posedge i_clk) begin
        if (i_uop.mul_en) begin
            r_prod   <= w_op_a * w_op_b;
            r_wb_dst <= i_uop.mul_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_en <= 1'b0;
        end else begin
            r_wb_en <= i_uop.mul_en;
        end
    end

    // round to nearest (ties up), drop fraction, saturate
    always_comb begin
        w_rnd = r_prod + RND_HALF;
        w_shr = w_rnd >>> rbe_pkg::FRAC_BITS;
        if (!w_shr[PW-1] && (|w_shr[PW-2:DW-1])) begin
            w_wb = SMAX;
        end else if (w_shr[PW-1] && !(&w_shr[PW-2:DW-1])) begin
            w_wb = SMIN;
        end else begin
            w_wb = w_shr[DW-1:0];
        end
    end

    // product write-back
    always_ff @(posedge i_clk) begin
        if (r_wb_en) begin
            case (r_wb_dst)
                rbe_pkg::D_HX: r_hx <= w_wb;
                rbe_pkg::D_HY: r_hy <= w_wb;
                rbe_pkg::D_HZ: r_hz <= w_wb;
                rbe_pkg::D_TX: r_tx <= w_wb;
                rbe_pkg::D_TY: r_ty <= w_wb;
                rbe_pkg::D_TZ: r_tz <= w_wb;
                default: ;
            endcase
        end
    end

    // accumulate: v + (-t) or v + (-t)/2, negation and sum saturate
    always_comb begin
        case (i_uop.add_axis)
            rbe_pkg::AX_X: begin w_v = r_vx; w_t = r_tx; end
            rbe_pkg::AX_Y: begin w_v = r_vy; w_t = r_ty; end
            rbe_pkg::AX_Z: begin w_v = r_vz; w_t = r_tz; end
            default:       begin w_v = r_vx; w_t = r_tx; end
        endcase
        w_neg = (w_t == SMIN) ? SMAX : -w_t;
        w_inc = i_uop.add_final ? w_neg : (w_neg >>> 1);
        w_sum = {w_v[DW-1], w_v} + {w_inc[DW-1], w_inc};
        if (w_sum[DW] != w_sum[DW-1]) begin
            w_acc = w_sum[DW] ? SMIN : SMAX;
        end else begin
            w_acc = w_sum[DW-1:0];
        end
    end

    // midpoint vector
    always_ff @(posedge i_clk) begin
        if (i_uop.add_en && !i_uop.add_final) begin
            case (i_uop.add_axis)
                rbe_pkg::AX_X: r_mx <= w_acc;
                rbe_pkg::AX_Y: r_my <= w_acc;
                rbe_pkg::AX_Z: r_mz <= w_acc;
                default: ;
            endcase
        end
    end

    // state vector: restart load or step update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= rbe_pkg::RST_INIT;
            r_vy <= rbe_pkg::RST_INIT;
            r_vz <= rbe_pkg::RST_INIT;
        end else if (i_load) begin
            r_vx <= i_cfg.init_x;
            r_vy <= i_cfg.init_y;
            r_vz <= i_cfg.init_z;
        end else if (i_uop.add_en && i_uop.add_final) begin
            case (i_uop.add_axis)
                rbe_pkg::AX_X: r_vx <= w_acc;
                rbe_pkg::AX_Y: r_vy <= w_acc;
                rbe_pkg::AX_Z: r_vz <= w_acc;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/rbe_chk.sv]
// ----------------------------------------------------------------------------
// rbe_chk
// Port-level checker for the rigid-body integrator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbe_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic signed [31:0]         o_omega_x,
    input wire logic signed [31:0]         o_omega_y,
    input wire logic signed [31:0]         o_omega_z,
    input wire logic [rbe_pkg::IDX_W-1:0]  o_step_index,
    input wire logic                       o_last
);

    // a stalled sample keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_omega_x) && $stable(o_omega_y)
            && $stable(o_omega_z) && $stable(o_step_index) && $stable(o_last)))
        else $error("stalled sample changed");

    // one request at a time: a taken request blocks the next cycle
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken back to back");

    // a new sample only shows while a request is in work
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_stall)
        else $error("sample appeared with the sequencer idle");

    // no sample in the cycle right after a request is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !$rose(o_valid))
        else $error("sample appeared too early");

endmodule

bind rigid_body_euler_rk2_step rbe_chk u_rbe_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_omega_x    (o_omega_x),
    .o_omega_y    (o_omega_y),
    .o_omega_z    (o_omega_z),
    .o_step_index (o_step_index),
    .o_last       (o_last)
);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rigid-body midpoint integrator. A local
// fixed-point model of the rk2 step predicts every sample. Directed tests
// cover reset defaults, run ends, clamped and shortened run lengths, and
// saturating settings. Random runs follow, under changing request and
// result back-pressure.
// ----------------------------------------------------------------------------

module testbench;

    import rbe_pkg::*;

    localparam int SETTLE    = 40;
    localparam int LIMIT     = 600000;
    localparam int LONG_RUN  = 200;

    localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

    // one emitted sample
    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic [IDX_W-1:0]   idx;
        logic               is_last;
    } t_sample;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_valid   = 1'b0;
    logic                o_stall;
    logic                i_restart = 1'b0;
    logic                o_valid;
    logic                i_stall   = 1'b0;
    logic signed [31:0]  o_omega_x;
    logic signed [31:0]  o_omega_y;
    logic signed [31:0]  o_omega_z;
    logic [IDX_W-1:0]    o_step_index;
    logic                o_last;

    // model settings and state
    logic [STEP_W-1:0]   h_cfg;
    logic signed [31:0]  gx_cfg, gy_cfg, gz_cfg;
    logic signed [31:0]  ix_cfg, iy_cfg, iz_cfg;
    logic [TOT_W-1:0]    total_cfg;
    logic signed [31:0]  wx_s, wy_s, wz_s;
    int                  run_pos;

    t_sample             pending_q[$];
    int                  mismatch_count = 0;
    int                  produced_count = 0;
    int                  send_idle_pct  = 0;
    int                  recv_idle_pct  = 0;
    int                  cycles         = 0;

    rigid_body_euler_rk2_step dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run guard
    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // fixed-point model
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] sat_word(input longint v);
        if (v > longint'(WORD_MAX)) return WORD_MAX;
        if (v < longint'(WORD_MIN)) return WORD_MIN;
        return v[31:0];
    endfunction

    // product, round half up, saturate
    function automatic logic signed [31:0] qmul(input longint a, input longint b);
        longint p;
        p = a * b + (longint'(1) <<< (FRAC_BITS - 1));
        return sat_word(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] sum_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat_word(longint'(a) + longint'(b));
    endfunction

    // -h*g*a*b with each product rounded, negation saturated
    function automatic logic signed [31:0] torque_term(input logic signed [31:0] g,
                                                       input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
        logic signed [31:0] t;
        t = qmul(longint'(h_cfg), g);
        t = qmul(t, a);
        t = qmul(t, b);
        return sat_word(-longint'(t));
    endfunction

    function automatic int run_limit();
        int lim;
        lim = int'(total_cfg);
        if (lim < 2) lim = 2;
        if (lim > MAX_STEPS) lim = MAX_STEPS;
        return lim;
    endfunction

    // one tick: returns 1 with the emitted sample, 0 on a finished run
    function automatic bit advance_body(input logic restart, output t_sample s);
        int                 lim;
        logic signed [31:0] kx, ky, kz, mx, my, mz;
        lim = run_limit();
        s   = '0;
        if (restart) begin
            wx_s    = ix_cfg;
            wy_s    = iy_cfg;
            wz_s    = iz_cfg;
            run_pos = 0;
        end else if (run_pos >= lim - 1) begin
            return 1'b0;
        end
        s.wx      = wx_s;
        s.wy      = wy_s;
        s.wz      = wz_s;
        s.idx     = run_pos[IDX_W-1:0];
        s.is_last = (run_pos == lim - 2);
        kx = torque_term(gx_cfg, wy_s, wz_s);
        ky = torque_term(gy_cfg, wx_s, wz_s);
        kz = torque_term(gz_cfg, wx_s, wy_s);
        // midpoint uses half of k1, floor shift
        mx = sum_sat(wx_s, kx >>> 1);
        my = sum_sat(wy_s, ky >>> 1);
        mz = sum_sat(wz_s, kz >>> 1);
        wx_s = sum_sat(wx_s, torque_term(gx_cfg, my, mz));
        wy_s = sum_sat(wy_s, torque_term(gy_cfg, mx, mz));
        wz_s = sum_sat(wz_s, torque_term(gz_cfg, mx, my));
        run_pos++;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // random stall on the result channel
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // compare each taken sample with the oldest prediction
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("sample %0d with nothing pending", o_step_index));
            end else begin
                want = pending_q.pop_front();
                if (o_omega_x !== want.wx)
                    report_mismatch($sformatf("omega_x got %0d expected %0d (index %0d)",
                                              o_omega_x, want.wx, want.idx));
                if (o_omega_y !== want.wy)
                    report_mismatch($sformatf("omega_y got %0d expected %0d (index %0d)",
                                              o_omega_y, want.wy, want.idx));
                if (o_omega_z !== want.wz)
                    report_mismatch($sformatf("omega_z got %0d expected %0d (index %0d)",
                                              o_omega_z, want.wz, want.idx));
                if (o_step_index !== want.idx)
                    report_mismatch($sformatf("step_index got %0d expected %0d",
                                              o_step_index, want.idx));
                if (o_last !== want.is_last)
                    report_mismatch($sformatf("last got %0b expected %0b (index %0d)",
                                              o_last, want.is_last, want.idx));
            end
        end
    end

    // ------------------------------------------------------------------
    // request side and configuration
    // ------------------------------------------------------------------

    // send one request; valid stays high after acceptance until the next call
    task automatic send_tick(input logic restart);
        t_sample s;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (advance_body(restart, s)) begin
            pending_q.push_back(s);
            produced_count++;
        end
    endtask

    // stop requests, drain all samples, let the sequencer finish
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write, setup then access; call only while idle
    task automatic write_reg(input t_reg_idx r, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_STEP:  h_cfg     = v[STEP_W-1:0];
            REG_GX:    gx_cfg    = v;
            REG_GY:    gy_cfg    = v;
            REG_GZ:    gz_cfg    = v;
            REG_INITX: ix_cfg    = v;
            REG_INITY: iy_cfg    = v;
            REG_INITZ: iz_cfg    = v;
            REG_TOTAL: total_cfg = v[TOT_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // random settings
    // ------------------------------------------------------------------

    function automatic logic [31:0] pick_signed(input int unsigned span);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60) return $urandom_range(2 * span) - span;
        if (sel < 85) return $urandom;
        return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endfunction

    function automatic logic [31:0] pick_step();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60) return $urandom_range(16777, 838861);
        if (sel < 85) return $urandom;
        return $urandom_range(1) ? 32'h7fffffff : 32'h0;
    endfunction

    function automatic logic [31:0] pick_total();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70) return $urandom_range(2, 40);
        if (sel < 85) return $urandom_range(0, 2047);
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'd1024;
            default: return 32'd1025;
        endcase
    endfunction

    task automatic shuffle_config();
        if ($urandom_range(1)) write_reg(REG_STEP,  pick_step());
        if ($urandom_range(1)) write_reg(REG_GX,    pick_signed(32'd1 << 24));
        if ($urandom_range(1)) write_reg(REG_GY,    pick_signed(32'd1 << 24));
        if ($urandom_range(1)) write_reg(REG_GZ,    pick_signed(32'd1 << 24));
        if ($urandom_range(1)) write_reg(REG_INITX, pick_signed(32'd1 << 26));
        if ($urandom_range(1)) write_reg(REG_INITY, pick_signed(32'd1 << 26));
        if ($urandom_range(1)) write_reg(REG_INITZ, pick_signed(32'd1 << 26));
        if ($urandom_range(1)) write_reg(REG_TOTAL, pick_total());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // first ticks run from the reset vector, then a restart
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // last flag, ticks past the end, run lengths below the minimum
    task automatic test_run_end();
        write_reg(REG_TOTAL, 32'd3);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();
        write_reg(REG_TOTAL, 32'd1);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
        write_reg(REG_TOTAL, 32'd0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // run length cut below the current position mid-run
    task automatic test_shortened_run();
        write_reg(REG_TOTAL, 32'd10);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        wait_idle();
        write_reg(REG_TOTAL, 32'd3);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // saturating settings, then a zero step that freezes the vector
    task automatic test_extremes();
        write_reg(REG_TOTAL, 32'd2047);
        write_reg(REG_STEP,  32'h7fffffff);
        write_reg(REG_GX,    32'h7fffffff);
        write_reg(REG_GY,    32'h80000000);
        write_reg(REG_GZ,    32'h7fffffff);
        write_reg(REG_INITX, 32'h7fffffff);
        write_reg(REG_INITY, 32'h80000000);
        write_reg(REG_INITZ, 32'h7fffffff);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();
        write_reg(REG_STEP,  32'h0);
        write_reg(REG_GX,    32'h80000000);
        write_reg(REG_GY,    32'h7fffffff);
        write_reg(REG_GZ,    32'h80000000);
        write_reg(REG_INITX, 32'h80000000);
        write_reg(REG_INITY, 32'h7fffffff);
        write_reg(REG_INITZ, 32'h80000000);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();
    endtask

    // long run with a run length above the maximum
    task automatic test_long_run();
        write_reg(REG_STEP,  32'(RST_STEP));
        write_reg(REG_GX,    RST_GX);
        write_reg(REG_GY,    RST_GY);
        write_reg(REG_GZ,    RST_GZ);
        write_reg(REG_INITX, 32'sd16777216);
        write_reg(REG_INITY, 32'sd8388608);
        write_reg(REG_INITZ, -32'sd4194304);
        write_reg(REG_TOTAL, 32'd2047);
        send_tick(1'b1);
        repeat (LONG_RUN - 1) send_tick(1'b0);
        wait_idle();
    endtask

    // random runs with fresh settings, plus noise and mid-run drains
    task automatic test_random(input int target, input int s_pct, input int r_pct);
        int base, lim, ticks, sel;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        base = produced_count;
        while (produced_count - base < target) begin
            sel = $urandom_range(99);
            if (sel < 80) begin
                if ($urandom_range(3) != 0) begin
                    wait_idle();
                    shuffle_config();
                end
                lim   = run_limit();
                ticks = $urandom_range(0, ((lim < 40) ? lim : 40) + 1);
                send_tick(1'b1);
                repeat (ticks) send_tick(1'b0);
            end else if (sel < 95) begin
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
            end else begin
                wait_idle();
                if ($urandom_range(1)) shuffle_config();
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        h_cfg     = RST_STEP;
        gx_cfg    = RST_GX;
        gy_cfg    = RST_GY;
        gz_cfg    = RST_GZ;
        ix_cfg    = RST_INIT;
        iy_cfg    = RST_INIT;
        iz_cfg    = RST_INIT;
        total_cfg = RST_TOTAL;
        wx_s      = RST_INIT;
        wy_s      = RST_INIT;
        wz_s      = RST_INIT;
        run_pos   = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 60;
        test_reset_defaults();
        test_run_end();
        test_shortened_run();
        test_extremes();
        test_random(150, 23, 60);
        test_random(150, 60, 23);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_run();
        test_random(150, 0, 0);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
